[rtl/core/char_lcd_write_formatter_defines.svh]
// assertion macros for the character lcd write formatter
`ifndef CHAR_LCD_WRITE_FORMATTER_DEFINES_SVH
`define CHAR_LCD_WRITE_FORMATTER_DEFINES_SVH

// implication in the same cycle, off during reset
`define CLWF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication into the next cycle, off during reset
`define CLWF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication that also holds while reset is applied
`define CLWF_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/core/clwf_pkg.sv]
// shared types, constants and helper functions of the lcd write formatter
`timescale 1ns / 1ps
`default_nettype none

package clwf_pkg;

   localparam int unsigned NumBits    = 32;
   localparam int unsigned BcdDigits  = 10;
   localparam int unsigned BcdBits    = 4 * BcdDigits;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = $clog2(QueueDepth);

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] GotoBase  = 8'h80;
   localparam logic [7:0] HiMask    = 8'hF0;
   localparam logic [7:0] LoMask    = 8'h0F;

   localparam logic [2:0] AddrEightBitBus = 3'd0;

   typedef enum logic [1:0] {
      ACT_COMMAND = 2'd0,
      ACT_CHAR    = 2'd1,
      ACT_NUMBER  = 2'd2,
      ACT_GOTO    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_CONV,
      FR_SIGN,
      FR_DIGITS
   } fr_state_type;

   typedef enum logic {
      BK_BYTE,
      BK_LOW
   } bk_state_type;

   typedef struct packed {
      logic       rs;
      logic [7:0] data;
      logic       last;
   } byte_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      unique case (row)
         2'd0: base = 8'h00;
         2'd1: base = 8'h40;
         2'd2: base = 8'h14;
         2'd3: base = 8'h54;
         default: base = 8'h00;
      endcase
      return base;
   endfunction

   // add three to every bcd digit of five or more
   function automatic logic [BcdBits-1:0] dabble_fix(input logic [BcdBits-1:0] bcd);
      logic [BcdBits-1:0] fixed;
      fixed = bcd;
      for (int i = 0; i < BcdDigits; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            fixed[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return fixed;
   endfunction

endpackage

`default_nettype wire

[rtl/core/clwf_front.sv]
// front end: accepts requests, converts numbers and queues the bytes to send
`timescale 1ns / 1ps
`default_nettype none

module clwf_front
   import clwf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_action,
   input  wire logic [7:0]          req_byte_value,
   input  wire logic signed [31:0]  req_number_value,
   input  wire logic [1:0]          req_row_index,
   input  wire logic [5:0]          req_column_index,
   input  wire queue_status_type    q_status,
   output logic                     push,
   output byte_entry_type           push_entry
);

   fr_state_type         state_ff, state_in;
   logic [NumBits-1:0]   bin_ff, bin_in;
   logic [BcdBits-1:0]   bcd_ff, bcd_in;
   logic                 neg_ff, neg_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [3:0]           dig_ff, dig_in;
   logic                 started_ff, started_in;

   logic                 accept;
   logic [BcdBits-1:0]   bcd_fixed;
   logic [3:0]           top_digit;
   logic                 last_digit;
   logic                 emit_digit;
   logic [NumBits-1:0]   number_raw;
   logic [NumBits-1:0]   magnitude;

   assign req_ready  = (state_ff == FR_IDLE) && !q_status.full;
   assign accept     = req_valid && req_ready;
   assign bcd_fixed  = dabble_fix(bcd_ff);
   assign top_digit  = bcd_ff[BcdBits-1 -: 4];
   assign last_digit = (dig_ff == 4'd0);
   assign emit_digit = started_ff || (top_digit != 4'd0) || last_digit;
   assign number_raw = $unsigned(req_number_value);
   assign magnitude  = number_raw[NumBits-1] ? (~number_raw + NumBits'(1)) : number_raw;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept && (action_type'(req_action) == ACT_NUMBER)) begin
               state_in = FR_CONV;
            end
         end
         FR_CONV: begin
            if (cnt_ff == 5'(NumBits - 1)) begin
               state_in = neg_ff ? FR_SIGN : FR_DIGITS;
            end
         end
         FR_SIGN: begin
            if (!q_status.full) begin
               state_in = FR_DIGITS;
            end
         end
         FR_DIGITS: begin
            if (last_digit && !q_status.full) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // queue writes
   always_comb begin
      push       = 1'b0;
      push_entry = '0;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               unique case (action_type'(req_action))
                  ACT_COMMAND: begin
                     push       = 1'b1;
                     push_entry = '{rs: 1'b0, data: req_byte_value, last: 1'b1};
                  end
                  ACT_CHAR: begin
                     push       = 1'b1;
                     push_entry = '{rs: 1'b1, data: req_byte_value, last: 1'b1};
                  end
                  ACT_GOTO: begin
                     push       = 1'b1;
                     push_entry = '{rs: 1'b0,
                                    data: GotoBase + row_base(req_row_index)
                                          + {2'b00, req_column_index},
                                    last: 1'b1};
                  end
                  ACT_NUMBER: begin
                     push = 1'b0;
                  end
                  default: push = 1'b0;
               endcase
            end
         end
         FR_CONV: begin
            push = 1'b0;
         end
         FR_SIGN: begin
            push       = !q_status.full;
            push_entry = '{rs: 1'b1, data: CharMinus, last: 1'b0};
         end
         FR_DIGITS: begin
            push       = emit_digit && !q_status.full;
            push_entry = '{rs: 1'b1, data: CharZero + {4'h0, top_digit}, last: last_digit};
         end
         default: push = 1'b0;
      endcase
   end

   // conversion datapath
   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      if (accept) begin
         bin_in     = magnitude;
         bcd_in     = '0;
         neg_in     = number_raw[NumBits-1];
         cnt_in     = 5'd0;
         dig_in     = 4'(BcdDigits - 1);
         started_in = 1'b0;
      end else if (state_ff == FR_CONV) begin
         bcd_in = {bcd_fixed[BcdBits-2:0], bin_ff[NumBits-1]};
         bin_in = {bin_ff[NumBits-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
      end else if ((state_ff == FR_DIGITS) && (!emit_digit || !q_status.full)) begin
         bcd_in     = {bcd_ff[BcdBits-5:0], 4'h0};
         dig_in     = dig_ff - 4'd1;
         started_in = started_ff || emit_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      dig_ff     <= dig_in;
      started_ff <= started_in;
   end

endmodule

`default_nettype wire

[rtl/core/clwf_queue.sv]
// short byte queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module clwf_queue
   import clwf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire byte_entry_type   push_entry,
   input  wire logic             pop,
   output byte_entry_type        pop_entry,
   output queue_status_type      status
);

   byte_entry_type         mem_ff [QueueDepth];
   logic [QueueAw-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QueueAw-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]       count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == (QueueAw + 1)'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_entry    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QueueAw'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QueueAw'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QueueAw + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QueueAw + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/clwf_back.sv]
// back end: turns queued bytes into bus writes, split into nibbles on the 4-bit bus, and holds the result register
`timescale 1ns / 1ps
`default_nettype none

module clwf_back
   import clwf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             eight_bit_bus,
   input  wire queue_status_type q_status,
   input  wire byte_entry_type   pop_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_register_select,
   output logic [7:0]            rsp_bus_value,
   output logic                  rsp_last_write
);

   bk_state_type     state_ff, state_in;
   byte_entry_type   cur_ff, cur_in;
   logic             valid_ff, valid_in;
   logic             rs_ff, rs_in;
   logic [7:0]       bus_ff, bus_in;
   logic             last_ff, last_in;
   logic             load;

   assign load = !valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_BYTE: begin
            if (pop && !eight_bit_bus) begin
               state_in = BK_LOW;
            end
         end
         BK_LOW: begin
            if (load) begin
               state_in = BK_BYTE;
            end
         end
         default: state_in = BK_BYTE;
      endcase
   end

   // outputs and result register
   always_comb begin
      pop      = 1'b0;
      cur_in   = cur_ff;
      valid_in = valid_ff && !rsp_ready;
      rs_in    = rs_ff;
      bus_in   = bus_ff;
      last_in  = last_ff;
      unique case (state_ff)
         BK_BYTE: begin
            pop = load && !q_status.empty;
            if (pop) begin
               cur_in   = pop_entry;
               valid_in = 1'b1;
               rs_in    = pop_entry.rs;
               if (eight_bit_bus) begin
                  bus_in  = pop_entry.data;
                  last_in = pop_entry.last;
               end else begin
                  bus_in  = (pop_entry.data & HiMask) >> 4;
                  last_in = 1'b0;
               end
            end
         end
         BK_LOW: begin
            if (load) begin
               valid_in = 1'b1;
               rs_in    = cur_ff.rs;
               bus_in   = cur_ff.data & LoMask;
               last_in  = cur_ff.last;
            end
         end
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_BYTE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      rs_ff   <= rs_in;
      bus_ff  <= bus_in;
      last_ff <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_register_select = rs_ff;
   assign rsp_bus_value       = bus_ff;
   assign rsp_last_write      = last_ff;

endmodule

`default_nettype wire

[rtl/core/char_lcd_write_formatter.sv]
// top level of the character lcd write formatter with its register port
// path: a command, character or goto byte is written into the queue, then loaded into the result
//   register; a number item first runs a 32-step conversion, then queues its sign and its digits
// rate: 1 bus write per cycle from the back end while the receiver is ready, two writes per
//   byte item on a 4-bit bus; a number item holds the front end until its last digit is queued
// reset: synchronous, clears the queue, the sequencers and selects the 4-bit bus
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_write_formatter
   import clwf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [7:0]         req_byte_value,
   input  wire logic signed [31:0] req_number_value,
   input  wire logic [1:0]         req_row_index,
   input  wire logic [5:0]         req_column_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_register_select,
   output logic [7:0]              rsp_bus_value,
   output logic                    rsp_last_write,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic               eight_bit_ff, eight_bit_in;
   logic               csr_write;
   queue_status_type   q_status;
   logic               push;
   byte_entry_type     push_entry;
   logic               pop;
   byte_entry_type     pop_entry;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr == AddrEightBitBus) ? {31'h0, eight_bit_ff} : 32'h0;

   always_comb begin
      eight_bit_in = eight_bit_ff;
      if (csr_write && (paddr == AddrEightBitBus)) begin
         eight_bit_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eight_bit_ff <= 1'b0;
      end else begin
         eight_bit_ff <= eight_bit_in;
      end
   end

   clwf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_byte_value   (req_byte_value),
      .req_number_value (req_number_value),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   clwf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   clwf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .eight_bit_bus       (eight_bit_ff),
      .q_status            (q_status),
      .pop_entry           (pop_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_register_select (rsp_register_select),
      .rsp_bus_value       (rsp_bus_value),
      .rsp_last_write      (rsp_last_write)
   );

endmodule

`default_nettype wire

[rtl/core/clwf_checker.sv]
// port-level checker for the lcd write formatter and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_write_formatter_defines.svh"

module clwf_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [1:0]         req_action,
   input wire logic [7:0]         req_byte_value,
   input wire logic signed [31:0] req_number_value,
   input wire logic [1:0]         req_row_index,
   input wire logic [5:0]         req_column_index,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_register_select,
   input wire logic [7:0]         rsp_bus_value,
   input wire logic               rsp_last_write,
   input wire logic               psel,
   input wire logic               penable,
   input wire logic               pwrite,
   input wire logic [2:0]         paddr,
   input wire logic [31:0]        pwdata,
   input wire logic [31:0]        prdata,
   input wire logic               pready
);

   // a stalled result item stays put
   `CLWF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped")
   `CLWF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_bus_value) && $stable(rsp_register_select) && $stable(rsp_last_write), "rsp item changed while stalled")
   // no result item right after reset
   `CLWF_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset, !rsp_valid, "rsp valid after reset")
   // register port is zero-wait and only bit zero reads back
   `CLWF_ASSERT_NOW(a_csr_read, clock, reset, psel, pready && (prdata[31:1] == 31'h0), "bad register read")

endmodule

bind char_lcd_write_formatter clwf_checker u_checker (.*);

`default_nettype wire

[test/testbench.sv]
// self-checking testbench for the character lcd write formatter
`timescale 1ns / 1ps

import clwf_pkg::*;

typedef struct {
   bit       rs;
   bit [7:0] bus;
   bit       last;
} lcd_write_type;

typedef struct {
   action_type       action;
   bit [7:0]         byte_value;
   bit signed [31:0] number_value;
   bit [1:0]         row;
   bit [5:0]         col;
} display_request_type;

class lcd_write_scoreboard;
   lcd_write_type expected_writes[$];
   bit            eight_bit;
   int            errors;

   task report_mismatch(string msg);
      if (errors < 100) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      errors++;
   endtask

   function int pending();
      return expected_writes.size();
   endfunction

   function bit [7:0] row_offset(bit [1:0] row);
      bit [7:0] base;
      case (row)
         2'd0: base = 8'h00;
         2'd1: base = 8'h40;
         2'd2: base = 8'h14;
         default: base = 8'h54;
      endcase
      return base;
   endfunction

   function void push_byte(bit rs, bit [7:0] b, bit last);
      lcd_write_type w;
      w.rs = rs;
      if (eight_bit) begin
         w.bus  = b;
         w.last = last;
         expected_writes.push_back(w);
      end else begin
         w.bus  = (b & HiMask) >> 4;
         w.last = 1'b0;
         expected_writes.push_back(w);
         w.bus  = b & LoMask;
         w.last = last;
         expected_writes.push_back(w);
      end
   endfunction

   function void note_request(display_request_type r);
      bit [31:0] raw;
      bit [31:0] mag;
      bit [3:0]  digits[10];
      int        cnt;
      bit        neg;
      raw = r.number_value;
      cnt = 0;
      case (r.action)
         ACT_COMMAND: push_byte(1'b0, r.byte_value, 1'b1);
         ACT_CHAR:    push_byte(1'b1, r.byte_value, 1'b1);
         ACT_GOTO:    push_byte(1'b0, GotoBase + row_offset(r.row) + {2'b00, r.col}, 1'b1);
         default: begin
            if (raw == 32'd0) begin
               push_byte(1'b1, CharZero, 1'b1);
            end else begin
               neg = raw[31];
               mag = neg ? (32'd0 - raw) : raw;
               while (mag != 32'd0 && cnt < 10) begin
                  digits[cnt] = 4'(mag % 10);
                  mag         = mag / 10;
                  cnt++;
               end
               if (neg) begin
                  push_byte(1'b1, CharMinus, 1'b0);
               end
               for (int i = cnt - 1; i >= 0; i--) begin
                  push_byte(1'b1, CharZero + {4'd0, digits[i]}, i == 0);
               end
            end
         end
      endcase
   endfunction

   task check_write(bit rs, bit [7:0] bus, bit last);
      lcd_write_type w;
      if (expected_writes.size() == 0) begin
         report_mismatch($sformatf("unexpected write rs %0b bus %02h last %0b", rs, bus, last));
      end else begin
         w = expected_writes.pop_front();
         if (w.rs !== rs) begin
            report_mismatch($sformatf("register_select %0b, expected %0b", rs, w.rs));
         end
         if (w.bus !== bus) begin
            report_mismatch($sformatf("bus_value %02h, expected %02h", bus, w.bus));
         end
         if (w.last !== last) begin
            report_mismatch($sformatf("last_write %0b, expected %0b", last, w.last));
         end
      end
   endtask
endclass

module testbench;

   localparam int CycleLimit = 600000;
   localparam int HoldCycles = 400;
   localparam int TailCycles = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = '0;
   logic [7:0]         req_byte_value = '0;
   logic signed [31:0] req_number_value = '0;
   logic [1:0]         req_row_index = '0;
   logic [5:0]         req_column_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_register_select;
   logic [7:0]         rsp_bus_value;
   logic               rsp_last_write;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   lcd_write_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_request = 1'b0;
   bit hold_served = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;

   char_lcd_write_formatter u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_byte_value(req_byte_value),
      .req_number_value(req_number_value),
      .req_row_index(req_row_index),
      .req_column_index(req_column_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_register_select(rsp_register_select),
      .rsp_bus_value(rsp_bus_value),
      .rsp_last_write(rsp_last_write),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_request && !hold_served) begin
         hold_served = 1'b1;
         hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      display_request_type r;
      if (!reset && req_valid && req_ready) begin
         r.action       = action_type'(req_action);
         r.byte_value   = req_byte_value;
         r.number_value = req_number_value;
         r.row          = req_row_index;
         r.col          = req_column_index;
         sb.note_request(r);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_write(rsp_register_select, rsp_bus_value, rsp_last_write);
      end
   end

   task automatic send_request(display_request_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_byte_value   <= r.byte_value;
      req_number_value <= r.number_value;
      req_row_index    <= r.row;
      req_column_index <= r.col;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_bus_mode(bit mode);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= AddrEightBitBus;
      pwdata  <= {31'd0, mode};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.eight_bit = mode;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {31'd0, mode}) begin
         sb.report_mismatch($sformatf("readback %08h, expected %0b", prdata, mode));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic display_request_type make_request(action_type a, bit [7:0] b,
                                                        bit signed [31:0] n, bit [1:0] row,
                                                        bit [5:0] col);
      display_request_type r;
      r.action       = a;
      r.byte_value   = b;
      r.number_value = n;
      r.row          = row;
      r.col          = col;
      return r;
   endfunction

   function automatic bit signed [31:0] random_number();
      bit signed [31:0] n;
      case ($urandom_range(5))
         0: n = $urandom_range(20);
         1: n = -$signed($urandom_range(20));
         2: begin
            case ($urandom_range(5))
               0: n = 32'sh7FFF_FFFF;
               1: n = 32'sh8000_0000;
               2: n = 32'sd1000000000;
               3: n = 32'sd999999999;
               4: n = -32'sd1000000000;
               default: n = -32'sd1;
            endcase
         end
         3: n = $signed($urandom) >>> $urandom_range(31);
         default: n = $urandom;
      endcase
      return n;
   endfunction

   function automatic display_request_type random_request();
      return make_request(action_type'($urandom_range(3)), 8'($urandom_range(255)),
                          (($urandom_range(3) == 0) ? $signed($urandom) : random_number()),
                          2'($urandom_range(3)), 6'($urandom_range(63)));
   endfunction

   task automatic run_phase(bit mode, int sidle, int rstall, int count);
      wait_drain();
      set_bus_mode(mode);
      send_idle  = sidle;
      recv_stall = rstall;
      repeat (count) send_request(random_request());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_bus_mode(1'b0);

      send_request(make_request(ACT_COMMAND, 8'h00, 32'sd0, 2'd0, 6'd0));
      send_request(make_request(ACT_COMMAND, 8'hFF, -32'sd1, 2'd3, 6'd63));
      send_request(make_request(ACT_CHAR, 8'h41, 32'sd5, 2'd1, 6'd7));
      send_request(make_request(ACT_CHAR, 8'h00, 32'sd0, 2'd0, 6'd0));
      send_request(make_request(ACT_CHAR, 8'hFF, 32'sh7FFF_FFFF, 2'd3, 6'd63));
      send_request(make_request(ACT_NUMBER, 8'h00, 32'sd0, 2'd0, 6'd0));
      send_request(make_request(ACT_NUMBER, 8'hFF, 32'sd7, 2'd3, 6'd63));
      send_request(make_request(ACT_NUMBER, 8'h00, -32'sd1, 2'd0, 6'd0));
      send_request(make_request(ACT_NUMBER, 8'h00, 32'sd10, 2'd0, 6'd0));
      send_request(make_request(ACT_NUMBER, 8'h00, 32'sh7FFF_FFFF, 2'd0, 6'd0));
      send_request(make_request(ACT_NUMBER, 8'h00, 32'sh8000_0000, 2'd0, 6'd0));
      send_request(make_request(ACT_NUMBER, 8'h00, 32'sd1000000000, 2'd0, 6'd0));
      send_request(make_request(ACT_NUMBER, 8'h00, -32'sd999999999, 2'd0, 6'd0));
      send_request(make_request(ACT_NUMBER, 8'h00, 32'sd4000000000, 2'd0, 6'd0));
      send_request(make_request(ACT_GOTO, 8'h00, 32'sd0, 2'd0, 6'd0));
      send_request(make_request(ACT_GOTO, 8'hFF, 32'sd0, 2'd1, 6'd39));
      send_request(make_request(ACT_GOTO, 8'h00, 32'sd0, 2'd1, 6'd63));
      send_request(make_request(ACT_GOTO, 8'h00, 32'sd0, 2'd2, 6'd20));
      send_request(make_request(ACT_GOTO, 8'h00, 32'sd0, 2'd3, 6'd39));
      // column past the display, sum wraps past 0xff
      send_request(make_request(ACT_GOTO, 8'h00, 32'sd0, 2'd3, 6'd63));

      run_phase(1'b1, 0, 0, 60);
      run_phase(1'b0, 88, 0, 60);
      run_phase(1'b1, 0, 88, 60);
      run_phase(1'b0, 9, 9, 60);
      wait_drain();
      set_bus_mode(1'b0);
      send_idle    = 0;
      recv_stall   = 0;
      hold_request = 1'b1;
      repeat (60) send_request(random_request());
      run_phase(1'b1, 9, 9, 70);

      wait_drain();
      repeat (TailCycles) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
